// ===== rtl/hdld_pkg.sv =====
package hdld_pkg;

    // Default line and label limits.
    localparam int unsigned MaxLineBytesDef  = 16;
    localparam int unsigned MinLabelCharsDef = 4;

    // Characters with a special role in the label.
    localparam logic [7:0] CharTab   = 8'h09;
    localparam logic [7:0] CharColon = 8'h3A;

    // Offsets that turn a digit character into its value.
    localparam logic [7:0] LetterOffset = 8'd55;
    localparam logic [7:0] DigitOffset  = 8'd48;
    localparam logic [7:0] CharUpperA   = 8'h41;

    // Widths of the output item.
    localparam int unsigned CountWidth = 5;

    // Cell columns of the data phase.
    localparam logic [1:0] ColHigh = 2'd0;
    localparam logic [1:0] ColLow  = 2'd1;
    localparam logic [1:0] ColSep  = 2'd2;

    // Line phase, one-hot.
    typedef enum logic [3:0] {
        PH_LABEL  = 4'b0001,
        PH_DATA   = 4'b0010,
        PH_STOP   = 4'b0100,
        PH_HEADER = 4'b1000
    } phase_t;

    // One result item as it leaves the line tracker.
    typedef struct packed {
        logic                  valid;
        logic [7:0]            byte_value;
        logic                  byte_valid;
        logic                  line_done;
        logic                  header_line;
        logic                  empty_line;
        logic [CountWidth-1:0] line_byte_count;
    } result_t;

    // Only '0'-'9' and 'A'-'F' count as hex digits.
    function automatic logic hex_digit(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    // Value of a digit character; letters from 'A' up, digits below.
    function automatic logic [7:0] char_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CharUpperA)
        begin
            v = c - LetterOffset;
        end
        else
        begin
            v = c - DigitOffset;
        end
        return v;
    endfunction

endpackage

// ===== rtl/hdld_line_fsm.sv =====
module hdld_line_fsm #(
    parameter int unsigned MAX_LINE_BYTES  = hdld_pkg::MaxLineBytesDef,
    parameter int unsigned MIN_LABEL_CHARS = hdld_pkg::MinLabelCharsDef
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        ch,
    input  logic              is_line_end,
    output hdld_pkg::result_t result
);

    localparam int unsigned PosWidth   = $clog2(MIN_LABEL_CHARS + 1);
    localparam int unsigned BytesWidth = $clog2(MAX_LINE_BYTES + 1);
    localparam logic [PosWidth-1:0]   MinLabel = PosWidth'(MIN_LABEL_CHARS);
    localparam logic [BytesWidth-1:0] MaxBytes = BytesWidth'(MAX_LINE_BYTES);

    hdld_pkg::phase_t       phase_reg, phase_next;
    logic [PosWidth-1:0]    label_pos_reg, label_pos_next;
    logic [1:0]             column_reg, column_next;
    logic [3:0]             high_nibble_reg, high_nibble_next;
    logic [BytesWidth-1:0]  bytes_reg, bytes_next;
    logic                   saw_char_reg, saw_char_next;

    logic                   is_hex;
    logic [7:0]             value;
    logic [BytesWidth+4:0]  bytes_ext;

    assign is_hex    = hdld_pkg::hex_digit(ch);
    assign value     = hdld_pkg::char_value(ch);
    assign bytes_ext = {5'b0, bytes_reg};

    // Next line state and the result of the current item.
    always_comb
    begin
        phase_next       = phase_reg;
        label_pos_next   = label_pos_reg;
        column_next      = column_reg;
        high_nibble_next = high_nibble_reg;
        bytes_next       = bytes_reg;
        saw_char_next    = saw_char_reg;
        result           = '0;

        if (is_line_end)
        begin
            // Report the line and start over.
            result.valid           = 1'b1;
            result.line_done       = 1'b1;
            result.header_line     = (phase_reg == hdld_pkg::PH_HEADER);
            result.empty_line      = !saw_char_reg;
            result.line_byte_count = bytes_ext[hdld_pkg::CountWidth-1:0];
            phase_next       = hdld_pkg::PH_LABEL;
            label_pos_next   = '0;
            column_next      = hdld_pkg::ColHigh;
            high_nibble_next = '0;
            bytes_next       = '0;
            saw_char_next    = 1'b0;
        end
        else
        begin
            saw_char_next = 1'b1;
            unique case (phase_reg) inside
                hdld_pkg::PH_LABEL:
                begin
                    if (!is_hex)
                    begin
                        if (label_pos_reg < MinLabel)
                        begin
                            phase_next = hdld_pkg::PH_HEADER;
                        end
                        else if (ch == hdld_pkg::CharTab)
                        begin
                            phase_next = hdld_pkg::PH_DATA;
                        end
                        else if (ch != hdld_pkg::CharColon)
                        begin
                            phase_next = hdld_pkg::PH_HEADER;
                        end
                    end
                    if (label_pos_reg < MinLabel)
                    begin
                        label_pos_next = label_pos_reg + 1'b1;
                    end
                end
                hdld_pkg::PH_DATA:
                begin
                    if (column_reg == hdld_pkg::ColHigh)
                    begin
                        if ((bytes_reg >= MaxBytes) || !is_hex)
                        begin
                            phase_next = hdld_pkg::PH_STOP;
                        end
                        else
                        begin
                            high_nibble_next = value[3:0];
                            column_next      = hdld_pkg::ColLow;
                        end
                    end
                    else if (column_reg == hdld_pkg::ColLow)
                    begin
                        // The low character completes a byte.
                        result.valid      = 1'b1;
                        result.byte_valid = 1'b1;
                        result.byte_value = {high_nibble_reg, 4'b0} + value;
                        bytes_next        = bytes_reg + 1'b1;
                        column_next       = hdld_pkg::ColSep;
                    end
                    else
                    begin
                        column_next = hdld_pkg::ColHigh;
                    end
                end
                hdld_pkg::PH_STOP, hdld_pkg::PH_HEADER:
                begin
                end
                default:
                begin
                    phase_next = hdld_pkg::PH_HEADER;
                end
            endcase
        end
    end

    // Line state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= hdld_pkg::PH_LABEL;
            label_pos_reg   <= '0;
            column_reg      <= hdld_pkg::ColHigh;
            high_nibble_reg <= '0;
            bytes_reg       <= '0;
            saw_char_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            label_pos_reg   <= label_pos_next;
            column_reg      <= column_next;
            high_nibble_reg <= high_nibble_next;
            bytes_reg       <= bytes_next;
            saw_char_reg    <= saw_char_next;
        end
    end

    // The byte count of a line never passes its limit.
    assert property (@(posedge clk) disable iff (!rst_n) bytes_reg <= MaxBytes)
        else $error("byte count above line limit");

    // A line break leaves a clean label phase behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && is_line_end) |=>
        (phase_reg == hdld_pkg::PH_LABEL) && (bytes_reg == '0) && !saw_char_reg)
        else $error("line state not cleared after line break");

    // Cells only ever use three columns, and only in the data phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (column_reg != hdld_pkg::ColHigh) |-> (phase_reg == hdld_pkg::PH_DATA))
        else $error("cell column away from the data phase");

    // A byte is produced only from the low column of the data phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.byte_valid) |=> (column_reg == hdld_pkg::ColSep))
        else $error("byte produced outside the low column");

endmodule

// ===== rtl/hex_dump_line_decoder_top.sv =====
// Channel  Direction  Fields (lowest bit first)
// s_axis   in         tdata: ch[7:0]; tlast: is_line_end
// m_axis   out        tdata: byte_value[7:0], line_byte_count[12:8], zero fill;
//                     tuser: byte_valid, header_line, empty_line; tlast: line_done
//
// One item is taken per cycle while s_tready is high; its result, if any, is offered
// from the output register. The input register feeds the line tracker, whose result
// lands in the output register.
// A stalled output register holds the input register; only then does s_tready drop.
// Items that give no result still pass through both stages in order.
// Reset clears the line state to the label phase and empties both registers.
module hex_dump_line_decoder_top #(
    parameter int unsigned MAX_LINE_BYTES  = hdld_pkg::MaxLineBytesDef,
    parameter int unsigned MIN_LABEL_CHARS = hdld_pkg::MinLabelCharsDef
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // ch
    input  logic        s_tlast,   // is_line_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // byte_value, line_byte_count, zero fill
    output logic [2:0]  m_tuser,   // byte_valid, header_line, empty_line
    output logic        m_tlast    // line_done
);

    logic              in_valid_reg;
    logic [7:0]        ch_reg;
    logic              line_end_reg;
    logic              advance;
    logic              step;
    hdld_pkg::result_t result;
    hdld_pkg::result_t out_reg;
    hdld_pkg::result_t out_next;

    // The pipeline moves whenever the output register is free or being emptied.
    assign advance  = !out_reg.valid || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            ch_reg       <= s_tdata;
            line_end_reg <= s_tlast;
        end
    end

    hdld_line_fsm #(
        .MAX_LINE_BYTES  (MAX_LINE_BYTES),
        .MIN_LABEL_CHARS (MIN_LABEL_CHARS)
    ) u_line_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .ch          (ch_reg),
        .is_line_end (line_end_reg),
        .result      (result)
    );

    // A result is valid only when the input register actually moved.
    always_comb
    begin
        out_next       = result;
        out_next.valid = step && result.valid;
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_reg.valid;
    assign m_tdata  = {3'b0, out_reg.line_byte_count, out_reg.byte_value};
    assign m_tuser  = {out_reg.empty_line, out_reg.header_line, out_reg.byte_valid};
    assign m_tlast  = out_reg.line_done;

endmodule

// ===== bench/tb_hex_dump_line_decoder_top.sv =====
// One decoded result: either a data byte or a line report.
typedef struct {
    logic [7:0]                      byte_value;
    logic                            byte_valid;
    logic                            line_done;
    logic                            header_line;
    logic                            empty_line;
    logic [hdld_pkg::CountWidth-1:0] line_byte_count;
} decoded_item_t;

// Tracks the line state of the decoder and holds the results still to come.
class hex_line_scoreboard;
    localparam logic [7:0] CharZero   = 8'h30;
    localparam logic [7:0] CharNine   = 8'h39;
    localparam logic [7:0] CharUpperF = 8'h46;

    hdld_pkg::phase_t line_phase;
    int unsigned      label_pos;
    logic [1:0]       cell_col;
    logic [3:0]       high_nib;
    int unsigned      line_bytes;
    bit               seen_char;
    decoded_item_t    pending_decodes[$];
    int unsigned      errors;

    function new();
        errors = 0;
        clear_line();
    endfunction

    function void clear_line();
        line_phase = hdld_pkg::PH_LABEL;
        label_pos  = 0;
        cell_col   = hdld_pkg::ColHigh;
        high_nib   = 4'd0;
        line_bytes = 0;
        seen_char  = 1'b0;
    endfunction

    function bit is_hex(logic [7:0] c);
        return ((c >= CharZero) && (c <= CharNine)) ||
               ((c >= hdld_pkg::CharUpperA) && (c <= CharUpperF));
    endfunction

    // Letters from 'A' up are offset differently from digits; the result wraps at 8 bits.
    function logic [7:0] nibble_of(logic [7:0] c);
        logic [7:0] v;
        if (c >= hdld_pkg::CharUpperA)
        begin
            v = c - hdld_pkg::LetterOffset;
        end
        else
        begin
            v = c - hdld_pkg::DigitOffset;
        end
        return v;
    endfunction

    function int unsigned pending();
        return pending_decodes.size();
    endfunction

    // Advances the line state by one accepted input item.
    function void accept_char(logic [7:0] ch, logic line_end);
        decoded_item_t d;
        logic [7:0]    nib;
        d = '{default: '0};

        // A line break reports the line and starts a new one.
        if (line_end)
        begin
            d.line_done       = 1'b1;
            d.header_line     = (line_phase == hdld_pkg::PH_HEADER);
            d.empty_line      = !seen_char;
            d.line_byte_count = line_bytes[hdld_pkg::CountWidth-1:0];
            pending_decodes.push_back(d);
            clear_line();
            return;
        end

        seen_char = 1'b1;

        // Label: early non-hex means header; later, tab ends it and colon is allowed.
        if (line_phase == hdld_pkg::PH_LABEL)
        begin
            if (!is_hex(ch))
            begin
                if (label_pos < hdld_pkg::MinLabelCharsDef)
                begin
                    line_phase = hdld_pkg::PH_HEADER;
                end
                else if (ch == hdld_pkg::CharTab)
                begin
                    line_phase = hdld_pkg::PH_DATA;
                end
                else if (ch != hdld_pkg::CharColon)
                begin
                    line_phase = hdld_pkg::PH_HEADER;
                end
            end
            if (label_pos < hdld_pkg::MinLabelCharsDef)
            begin
                label_pos++;
            end
            return;
        end

        if (line_phase != hdld_pkg::PH_DATA)
        begin
            return;
        end

        // Data cells: high digit, low character, ignored separator.
        case (cell_col)
            hdld_pkg::ColHigh:
            begin
                if ((line_bytes >= hdld_pkg::MaxLineBytesDef) || !is_hex(ch))
                begin
                    line_phase = hdld_pkg::PH_STOP;
                end
                else
                begin
                    nib      = nibble_of(ch);
                    high_nib = nib[3:0];
                    cell_col = hdld_pkg::ColLow;
                end
            end
            hdld_pkg::ColLow:
            begin
                d.byte_value = {high_nib, 4'd0} + nibble_of(ch);
                d.byte_valid = 1'b1;
                pending_decodes.push_back(d);
                line_bytes++;
                cell_col = hdld_pkg::ColSep;
            end
            default:
            begin
                cell_col = hdld_pkg::ColHigh;
            end
        endcase
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Compares one output item with the oldest pending result.
    function void check_decoded(logic [15:0] data, logic [2:0] user, logic last);
        decoded_item_t want;
        if (pending_decodes.size() == 0)
        begin
            $error("unexpected result: tdata %h, tuser %b, tlast %b", data, user, last);
            errors++;
            return;
        end
        want = pending_decodes.pop_front();
        check_field("byte_value", want.byte_value, data[7:0]);
        check_field("line_byte_count", 8'(want.line_byte_count), 8'(data[12:8]));
        check_field("byte_valid", 8'(want.byte_valid), 8'(user[0]));
        check_field("line_done", 8'(want.line_done), 8'(last));
        check_field("header_line", 8'(want.header_line), 8'(user[1]));
        check_field("empty_line", 8'(want.empty_line), 8'(user[2]));
    endfunction
endclass

module tb_hex_dump_line_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DirectedItems = 30;
    localparam int unsigned RandomItems   = 1500;
    localparam int unsigned CalmTail      = 250;
    localparam int unsigned CycleLimit    = 400000;
    localparam logic [7:0]  CharSpace     = 8'h20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // ch
    logic        s_tlast = 1'b0;   // is_line_end
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [15:0] m_tdata;          // byte_value, line_byte_count, zero fill
    logic [2:0]  m_tuser;          // byte_valid, header_line, empty_line
    logic        m_tlast;          // line_done

    hex_line_scoreboard scoreboard = new();
    int unsigned items_sent = 0;
    int unsigned cycle_count;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;

    hex_dump_line_decoder_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Random upper-case hex digit.
    function automatic logic [7:0] rand_hex_char();
        int unsigned idx;
        idx = $urandom_range(0, 15);
        return (idx < 10) ? 8'(hdld_pkg::DigitOffset + idx) :
                            8'(hdld_pkg::LetterOffset + idx);
    endfunction

    // Random character that is not an upper-case hex digit.
    function automatic logic [7:0] rand_non_hex_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (scoreboard.is_hex(c))
        begin
            c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    // Offers one item and waits until it is taken, then maybe idles.
    task automatic send_item(input logic [7:0] ch, input logic line_end);
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= line_end;
        do
            @(posedge clk);
        while (!s_tready);
        scoreboard.accept_char(ch, line_end);
        items_sent++;
        if (tx_idle_on && ($urandom_range(0, 7) == 0))
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
        begin
            send_item(text[i], 1'b0);
        end
    endtask

    // The character that travels with a line break is random, since it is ignored.
    task automatic end_line();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Holds the sender off until every pending result has come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (scoreboard.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // One random line, mostly well formed, sometimes noise or broken.
    task automatic send_random_line();
        int unsigned kind;
        int unsigned count;
        int unsigned tail;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            // A short label ending in a tab makes a header.
            count = (kind < 5) ? $urandom_range(0, 3) : $urandom_range(4, 8);
            for (int i = 0; i < count; i++)
            begin
                if ((i >= 4) && ($urandom_range(0, 2) == 0))
                begin
                    send_item(hdld_pkg::CharColon, 1'b0);
                end
                else
                begin
                    send_item(rand_hex_char(), 1'b0);
                end
            end
            send_item(hdld_pkg::CharTab, 1'b0);
            count = ($urandom_range(0, 5) == 0) ? $urandom_range(16, 20) :
                                                  $urandom_range(0, 16);
            for (int i = 0; i < count; i++)
            begin
                send_item(rand_hex_char(), 1'b0);
                send_item(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                          rand_hex_char(), 1'b0);
                send_item(($urandom_range(0, 1) == 0) ? CharSpace :
                          8'($urandom_range(0, 255)), 1'b0);
            end
            tail = $urandom_range(0, 5);
            case (tail)
                0: send_item(rand_hex_char(), 1'b0);
                1:
                begin
                    send_item(rand_hex_char(), 1'b0);
                    send_item(rand_hex_char(), 1'b0);
                end
                2:
                begin
                    send_item(rand_non_hex_char(), 1'b0);
                    repeat ($urandom_range(0, 4)) send_item(8'($urandom_range(0, 255)), 1'b0);
                end
                default: ;
            endcase
        end
        else if (kind < 80)
        begin
            // Noise, with a tab somewhere now and then.
            count = $urandom_range(0, 12);
            for (int i = 0; i < count; i++)
            begin
                send_item(($urandom_range(0, 5) == 0) ? hdld_pkg::CharTab :
                          8'($urandom_range(0, 255)), 1'b0);
            end
        end
        else if (kind < 88)
        begin
            // Good start, then a bad character after the first four.
            for (int i = 0; i < 4; i++)
            begin
                send_item(rand_hex_char(), 1'b0);
            end
            send_item(rand_non_hex_char(), 1'b0);
            repeat ($urandom_range(0, 6)) send_item(8'($urandom_range(0, 255)), 1'b0);
        end
        else if (kind >= 93)
        begin
            // Label with no tab.
            count = $urandom_range(1, 8);
            for (int i = 0; i < count; i++)
            begin
                send_item(rand_hex_char(), 1'b0);
            end
        end
        end_line();
    endtask

    // Output side: accepted results go to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            scoreboard.check_decoded(m_tdata, m_tuser, m_tlast);
        end
    end

    // Output side: stall in random bursts while allowed.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rx_idle_on && ($urandom_range(0, 5) == 0))
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    // Give up if the run hangs.
    initial
    begin
        for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++)
        begin
            @(posedge clk);
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed lines: empty, early header, data line that stops, half pair, no tab.
        end_line();
        send_item(8'hFF, 1'b0);
        end_line();
        send_text("0F9A:\tF");
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("0G-X1");
        end_line();
        send_text("ABCD\t7");
        end_line();
        send_text("1234");
        end_line();
        drain_results();

        // Random lines; the last part runs with no idling on either side.
        while (items_sent < DirectedItems + RandomItems)
        begin
            if (items_sent + CalmTail >= DirectedItems + RandomItems)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            else
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            send_random_line();
            if ($urandom_range(0, 29) == 0)
            begin
                drain_results();
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (scoreboard.errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ===== files.f =====
rtl/hdld_pkg.sv
rtl/hdld_line_fsm.sv
rtl/hex_dump_line_decoder_top.sv
bench/tb_hex_dump_line_decoder_top.sv
